>>> rtl/rtcss_pkg.sv
package rtcss_pkg;

	// status codes reported with every result
	localparam logic [1:0] STATUS_OK         = 2'd0;
	localparam logic [1:0] STATUS_NO_IRQ     = 2'd1;
	localparam logic [1:0] STATUS_NOT_UPDATE = 2'd2;

	// interrupt flag bits
	localparam int unsigned FLAG_IRQ_BIT    = 7;
	localparam int unsigned FLAG_UPDATE_BIT = 4;

	// time-of-day limits
	localparam logic [7:0] NOT_LOADED = 8'hFF;
	localparam logic [7:0] SEC_WRAP   = 8'd60;
	localparam logic [7:0] MIN_WRAP   = 8'd60;
	localparam logic [7:0] HRS_WRAP   = 8'd24;

	// h*3600 + m*60 + s for 8-bit fields stays below 2**20
	localparam int unsigned TOTAL_W = 20;

	typedef struct packed {
		logic [7:0] irq_flags;
		logic [7:0] chip_hours;
		logic [7:0] chip_minutes;
		logic [7:0] chip_seconds;
	} event_t;

	typedef struct packed {
		logic [1:0] status;
		logic       time_valid;
		logic [7:0] hours;
		logic [7:0] minutes;
		logic [7:0] seconds;
		logic       is_stable;
	} result_t;

	// bcd to binary, no check on nibbles above nine
	function automatic logic [7:0] bcd_decode(input logic [7:0] v);
		logic [7:0] tens;
		tens = 8'(v[7:4]) * 8'd10;
		return tens + 8'(v[3:0]);
	endfunction

	// seconds since midnight, as a plain integer
	function automatic logic [TOTAL_W-1:0] total_seconds(
		input logic [7:0] h,
		input logic [7:0] m,
		input logic [7:0] s
	);
		return TOTAL_W'(h) * TOTAL_W'(3600) + TOTAL_W'(m) * TOTAL_W'(60) + TOTAL_W'(s);
	endfunction

endpackage

>>> rtl/rtcss_shadow.sv
module rtcss_shadow import rtcss_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    bcd_mode,
	input  event_t  evt,
	input  logic    commit,
	output result_t res
);

	logic [7:0] hours_q;
	logic [7:0] minutes_q;
	logic [7:0] seconds_q;
	logic       locked_q;

	logic [7:0] hours_d;
	logic [7:0] minutes_d;
	logic [7:0] seconds_d;
	logic       locked_d;
	logic [1:0] status;

	logic [7:0] sec_inc;
	logic [7:0] min_inc;
	logic [7:0] hrs_inc;
	logic [7:0] new_h;
	logic [7:0] new_m;
	logic [7:0] new_s;
	logic       lock_hit;

	// one-second advance of the local counters
	assign sec_inc = seconds_q + 8'd1;
	assign min_inc = minutes_q + 8'd1;
	assign hrs_inc = hours_q + 8'd1;

	// chip time, decoded when the chip runs in bcd
	assign new_h = bcd_mode ? bcd_decode(evt.chip_hours) : evt.chip_hours;
	assign new_m = bcd_mode ? bcd_decode(evt.chip_minutes) : evt.chip_minutes;
	assign new_s = bcd_mode ? bcd_decode(evt.chip_seconds) : evt.chip_seconds;

	// chip sample lands exactly one second after the shadow time
	assign lock_hit = (hours_q != NOT_LOADED) &&
		(total_seconds(new_h, new_m, new_s) ==
		 total_seconds(hours_q, minutes_q, seconds_q) + TOTAL_W'(1));

	// next state for this event
	always_comb begin
		hours_d   = hours_q;
		minutes_d = minutes_q;
		seconds_d = seconds_q;
		locked_d  = locked_q;
		if (!evt.irq_flags[FLAG_IRQ_BIT]) begin
			status = STATUS_NO_IRQ;
		end else if (!evt.irq_flags[FLAG_UPDATE_BIT]) begin
			status = STATUS_NOT_UPDATE;
		end else begin
			status = STATUS_OK;
			if (locked_q) begin
				if (sec_inc == SEC_WRAP) begin
					seconds_d = 8'd0;
					if (min_inc == MIN_WRAP) begin
						minutes_d = 8'd0;
						hours_d   = (hrs_inc == HRS_WRAP) ? 8'd0 : hrs_inc;
					end else begin
						minutes_d = min_inc;
					end
				end else begin
					seconds_d = sec_inc;
				end
			end else begin
				hours_d   = new_h;
				minutes_d = new_m;
				seconds_d = new_s;
				locked_d  = lock_hit;
			end
		end
	end

	// result reflects the state after this event
	always_comb begin
		res.status     = status;
		res.time_valid = (hours_d != NOT_LOADED);
		res.hours      = hours_d;
		res.minutes    = minutes_d;
		res.seconds    = seconds_d;
		res.is_stable  = locked_d;
	end

	// shadow time registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hours_q   <= NOT_LOADED;
			minutes_q <= 8'd0;
			seconds_q <= 8'd0;
			locked_q  <= 1'b0;
		end else if (commit) begin
			hours_q   <= hours_d;
			minutes_q <= minutes_d;
			seconds_q <= seconds_d;
			locked_q  <= locked_d;
		end
	end

endmodule

>>> rtl/rtc_time_shadow_sync.sv
// RTC shadow-time synchronizer. Each input transaction is one RTC interrupt event
// (flag byte plus raw hour, minute and second registers) and yields exactly one
// result transaction. Events without the pending flag (bit 7) or the update flag
// (bit 4) report status 1 or 2 and leave the shadow time untouched. Update events
// sample the chip time (bcd-decoded when bcd_mode is set) until two samples are
// exactly one second apart; after that the block counts locally, one second per
// update event, wrapping at 60/60/24. Throughput is one event per clock while out_ready
// does not hold a result back; each accepted event passes through an input
// register and a result register, with the shadow time updated in the same
// cycle an event moves to the result register. bcd_mode is written over the cfg
// channel, which is always ready, and must only change while the block is idle.
module rtc_time_shadow_sync import rtcss_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] irq_flags,
	input  logic [7:0] chip_hours,
	input  logic [7:0] chip_minutes,
	input  logic [7:0] chip_seconds,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] status,
	output logic       time_valid,
	output logic [7:0] out_hours,
	output logic [7:0] out_minutes,
	output logic [7:0] out_seconds,
	output logic       is_stable
);

	logic    bcd_mode_q;
	logic    valid_s1;
	event_t  evt_s1;
	logic    valid_s2;
	result_t res_s2;
	result_t res_next;
	logic    advance_s1;

	// configuration register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bcd_mode_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			bcd_mode_q <= cfg_data;
		end
	end

	// handshake between input and result stages
	assign advance_s1 = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready   = !valid_s1 || advance_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (!valid_s2 || out_ready) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			evt_s1.irq_flags    <= irq_flags;
			evt_s1.chip_hours   <= chip_hours;
			evt_s1.chip_minutes <= chip_minutes;
			evt_s1.chip_seconds <= chip_seconds;
		end
	end

	// shadow time state and per-event update
	rtcss_shadow u_shadow (
		.clk      (clk),
		.arst_n   (arst_n),
		.bcd_mode (bcd_mode_q),
		.evt      (evt_s1),
		.commit   (advance_s1),
		.res      (res_next)
	);

	// result register
	always_ff @(posedge clk) begin
		if (advance_s1) begin
			res_s2 <= res_next;
		end
	end

	assign out_valid   = valid_s2;
	assign status      = res_s2.status;
	assign time_valid  = res_s2.time_valid;
	assign out_hours   = res_s2.hours;
	assign out_minutes = res_s2.minutes;
	assign out_seconds = res_s2.seconds;
	assign is_stable   = res_s2.is_stable;

endmodule

>>> rtl/rtcss_checker.sv
module rtcss_checker import rtcss_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] status,
	input logic       time_valid,
	input logic [7:0] out_hours,
	input logic [7:0] out_minutes,
	input logic [7:0] out_seconds,
	input logic       is_stable
);

	logic seen_stable_q;

	// remembers that a locked result has been delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_stable_q <= 1'b0;
		end else if (out_valid && out_ready && is_stable) begin
			seen_stable_q <= 1'b1;
		end
	end

	// status is one of the defined codes
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == STATUS_OK || status == STATUS_NO_IRQ ||
			status == STATUS_NOT_UPDATE))
		else $error("undefined status code");

	// time_valid tracks the loaded marker in the hours field
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (time_valid == (out_hours != NOT_LOADED)))
		else $error("time_valid disagrees with out_hours");

	// once locked, the block never unlocks
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && seen_stable_q) |-> is_stable)
		else $error("is_stable dropped after lock");

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(status) &&
			$stable(out_hours) && $stable(out_minutes) && $stable(out_seconds) &&
			$stable(is_stable) && $stable(time_valid)))
		else $error("stalled result changed");

endmodule

bind rtc_time_shadow_sync rtcss_checker u_checker (.*);
